// File: hw/rtl/dmx_pixel_channel_mapper_top_defines.svh
// Assertion macros shared by the pixel channel mapper RTL.
`ifndef DMX_PIXEL_CHANNEL_MAPPER_TOP_DEFINES_SVH
`define DMX_PIXEL_CHANNEL_MAPPER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while reset is low.
`define DPCM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define DPCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPCM_ASSERT(lbl, clk, rst, prop, msg)
`define DPCM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/dpcm_pkg.sv
// Types, widths and register codes of the pixel channel mapper.
package dpcm_pkg;

   localparam int UNIVERSE_SLOTS_DEF = 512;
   localparam int MAX_UNIVERSES_DEF  = 16;
   localparam int MAX_PIXELS_DEF     = 1024;

   localparam int PIX_IDX_W  = 10;
   localparam int CH_W       = 10;
   localparam int COUNT_W    = 11;
   localparam int UNI_W      = 15;
   localparam int UNI_OUT_W  = 16;
   localparam int OFS_W      = 4;
   localparam int CPP_W      = 3;
   localparam int RGB_CHANNELS = 3;
   localparam int BASE_W     = 13;
   localparam int QUO_W      = 7;
   localparam int REM_W      = 11;
   localparam int PIX_LIM_W  = 14;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W    = 19;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_START_CHANNEL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_ENABLE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CCT_ENABLE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_UNIVERSE = 3'd4;

   localparam logic [CH_W-1:0]    START_CHANNEL_RST  = 10'd1;
   localparam logic [COUNT_W-1:0] PIXEL_COUNT_RST    = 11'd1;
   localparam logic [UNI_W-1:0]   START_UNIVERSE_RST = 15'd0;

   typedef struct packed {
      logic [CH_W-1:0]    start_channel;
      logic [COUNT_W-1:0] pixel_count;
      logic               white_enable;
      logic               cct_enable;
      logic [UNI_W-1:0]   start_universe;
   } cfg_type;

   typedef struct packed {
      logic              ok;
      logic [BASE_W-1:0] base;
   } loc_type;

   typedef struct packed {
      logic             ok;
      logic [QUO_W-1:0] quo;
      logic [CH_W-1:0]  rem;
   } div_type;

   typedef struct packed {
      logic                 ok;
      logic [OFS_W-1:0]     universe_offset;
      logic [UNI_OUT_W-1:0] artnet_universe;
      logic [UNI_OUT_W-1:0] sacn_universe;
      logic [CH_W-1:0]      channel_red;
      logic [CH_W-1:0]      channel_green;
      logic [CH_W-1:0]      channel_blue;
   } rsp_type;

endpackage

// File: hw/rtl/dpcm_if.sv
// Request and response channel interfaces of the pixel channel mapper.
interface dpcm_req_if;
   import dpcm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PIX_IDX_W-1:0] pixel_index;
   modport source(output valid, output pixel_index, input ready);
   modport sink(input valid, input pixel_index, output ready);
endinterface

interface dpcm_rsp_if;
   import dpcm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 ok;
   logic [OFS_W-1:0]     universe_offset;
   logic [UNI_OUT_W-1:0] artnet_universe;
   logic [UNI_OUT_W-1:0] sacn_universe;
   logic [CH_W-1:0]      channel_red;
   logic [CH_W-1:0]      channel_green;
   logic [CH_W-1:0]      channel_blue;
   modport source(output valid, output ok, output universe_offset, output artnet_universe,
                  output sacn_universe, output channel_red, output channel_green,
                  output channel_blue, input ready);
   modport sink(input valid, input ok, input universe_offset, input artnet_universe,
                input sacn_universe, input channel_red, input channel_green,
                input channel_blue, output ready);
endinterface

// File: hw/rtl/dpcm_locate.sv
// First stage: slot offset of the pixel and the range checks.
module dpcm_locate #(
   parameter int UNIVERSE_SLOTS = dpcm_pkg::UNIVERSE_SLOTS_DEF,
   parameter int MAX_PIXELS     = dpcm_pkg::MAX_PIXELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dpcm_pkg::cfg_type cfg,
   dpcm_req_if.sink          req_ch,
   output logic              loc_valid,
   input  logic              loc_ready,
   output dpcm_pkg::loc_type loc
);
   import dpcm_pkg::*;

   localparam logic [CH_W-1:0]      Slots    = CH_W'(UNIVERSE_SLOTS);
   localparam logic [PIX_LIM_W-1:0] PixLimit = PIX_LIM_W'(MAX_PIXELS);

   logic              v_ff, v_in;
   loc_type           loc_ff, loc_in;
   logic [CPP_W-1:0]  cpp;
   logic [BASE_W-1:0] scaled;
   logic              stage_ready;

   assign stage_ready  = !v_ff || loc_ready;
   assign req_ch.ready = stage_ready;

   always_comb begin
      cpp = CPP_W'(RGB_CHANNELS) + CPP_W'(cfg.white_enable) + CPP_W'(cfg.cct_enable);
      scaled = BASE_W'(req_ch.pixel_index) * BASE_W'(cpp);
      loc_in.base = BASE_W'(cfg.start_channel) - BASE_W'(1) + scaled;
      loc_in.ok = (PIX_LIM_W'(req_ch.pixel_index) < PIX_LIM_W'(cfg.pixel_count))
               && (PIX_LIM_W'(req_ch.pixel_index) < PixLimit)
               && (cfg.start_channel != '0)
               && (cfg.start_channel <= Slots);
      v_in = stage_ready ? req_ch.valid : v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready) begin
         loc_ff <= loc_in;
      end
   end

   assign loc_valid = v_ff;
   assign loc       = loc_ff;

endmodule

// File: hw/rtl/dpcm_divide.sv
// Three stages that split the slot offset into universe and slot within it.
`include "dmx_pixel_channel_mapper_top_defines.svh"
module dpcm_divide #(
   parameter int UNIVERSE_SLOTS = dpcm_pkg::UNIVERSE_SLOTS_DEF,
   parameter int MAX_UNIVERSES  = dpcm_pkg::MAX_UNIVERSES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              loc_valid,
   output logic              loc_ready,
   input  dpcm_pkg::loc_type loc,
   output logic              div_valid,
   input  logic              div_ready,
   output dpcm_pkg::div_type div
);
   import dpcm_pkg::*;

   localparam logic [CH_W-1:0]    Slots  = CH_W'(UNIVERSE_SLOTS);
   localparam logic [RECIP_W-1:0] Recip  = RECIP_W'((1 << RECIP_SHIFT) / UNIVERSE_SLOTS);
   localparam logic [QUO_W-1:0]   MaxUni = QUO_W'(MAX_UNIVERSES);

   logic                      a_rdy, b_rdy, c_rdy;
   logic                      a_v_ff, a_v_in, b_v_ff, b_v_in, c_v_ff, c_v_in;
   logic                      a_ok_ff, b_ok_ff;
   logic [BASE_W-1:0]         a_base_ff;
   logic [QUO_W-1:0]          a_quo_ff, a_quo_in, b_quo_ff;
   logic [REM_W-1:0]          b_rem_ff, b_rem_in;
   logic [BASE_W+RECIP_W-1:0] est_prod;
   logic [QUO_W+CH_W-1:0]     back_prod;
   logic                      fix;
   logic [QUO_W-1:0]          quo_fixed;
   div_type                   c_ff, c_in;

   assign c_rdy     = !c_v_ff || div_ready;
   assign b_rdy     = !b_v_ff || c_rdy;
   assign a_rdy     = !a_v_ff || b_rdy;
   assign loc_ready = a_rdy;

   always_comb begin
      est_prod = (BASE_W+RECIP_W)'(loc.base) * (BASE_W+RECIP_W)'(Recip);
      a_quo_in = QUO_W'(est_prod >> RECIP_SHIFT);
      back_prod = (QUO_W+CH_W)'(a_quo_ff) * (QUO_W+CH_W)'(Slots);
      b_rem_in = REM_W'(a_base_ff - BASE_W'(back_prod));
      fix = b_rem_ff >= REM_W'(Slots);
      quo_fixed = fix ? b_quo_ff + QUO_W'(1) : b_quo_ff;
      c_in.quo = quo_fixed;
      c_in.rem = fix ? CH_W'(b_rem_ff - REM_W'(Slots)) : CH_W'(b_rem_ff);
      c_in.ok  = b_ok_ff && (quo_fixed < MaxUni);
      a_v_in = a_rdy ? loc_valid : a_v_ff;
      b_v_in = b_rdy ? a_v_ff : b_v_ff;
      c_v_in = c_rdy ? b_v_ff : c_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         c_v_ff <= c_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy) begin
         a_ok_ff   <= loc.ok;
         a_base_ff <= loc.base;
         a_quo_ff  <= a_quo_in;
      end
      if (b_rdy) begin
         b_ok_ff  <= a_ok_ff;
         b_quo_ff <= a_quo_ff;
         b_rem_ff <= b_rem_in;
      end
      if (c_rdy) begin
         c_ff <= c_in;
      end
   end

   assign div_valid = c_v_ff;
   assign div       = c_ff;

   `DPCM_ASSERT(a_rem_one_fix, clock, reset, b_v_ff |-> b_rem_ff < (REM_W'(Slots) << 1), "Estimated quotient is off by more than one.")
   `DPCM_ASSERT(a_out_hold, clock, reset, c_v_ff && !div_ready |=> c_v_ff && $stable(c_ff), "Stalled division result changed.")
   `DPCM_ASSERT(a_quo_range, clock, reset, c_v_ff && c_ff.ok |-> c_ff.quo < MaxUni, "Valid item has a universe beyond the limit.")

endmodule

// File: hw/rtl/dpcm_format.sv
// Output stage: universe numbers, color slots and the failure result.
`include "dmx_pixel_channel_mapper_top_defines.svh"
module dpcm_format (
   input  logic              clock,
   input  logic              reset,
   input  dpcm_pkg::cfg_type cfg,
   input  logic              div_valid,
   output logic              div_ready,
   input  dpcm_pkg::div_type div,
   dpcm_rsp_if.source        rsp_ch
);
   import dpcm_pkg::*;

   logic    v_ff, v_in;
   rsp_type rsp_ff, rsp_in;
   logic    stage_ready;

   assign stage_ready = !v_ff || rsp_ch.ready;
   assign div_ready   = stage_ready;

   always_comb begin
      rsp_in = '0;
      if (div.ok) begin
         rsp_in.ok              = 1'b1;
         rsp_in.universe_offset = OFS_W'(div.quo);
         rsp_in.artnet_universe = UNI_OUT_W'(cfg.start_universe) + UNI_OUT_W'(div.quo);
         rsp_in.sacn_universe   = UNI_OUT_W'(cfg.start_universe) + UNI_OUT_W'(div.quo)
                                + UNI_OUT_W'(1);
         rsp_in.channel_red     = div.rem + CH_W'(1);
         rsp_in.channel_green   = div.rem + CH_W'(2);
         rsp_in.channel_blue    = div.rem + CH_W'(3);
      end
      v_in = stage_ready ? div_valid : v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid           = v_ff;
   assign rsp_ch.ok              = rsp_ff.ok;
   assign rsp_ch.universe_offset = rsp_ff.universe_offset;
   assign rsp_ch.artnet_universe = rsp_ff.artnet_universe;
   assign rsp_ch.sacn_universe   = rsp_ff.sacn_universe;
   assign rsp_ch.channel_red     = rsp_ff.channel_red;
   assign rsp_ch.channel_green   = rsp_ff.channel_green;
   assign rsp_ch.channel_blue    = rsp_ff.channel_blue;

   `DPCM_ASSERT(a_fail_zero, clock, reset, rsp_ch.valid && !rsp_ch.ok |-> rsp_ch.universe_offset == '0 && rsp_ch.artnet_universe == '0 && rsp_ch.sacn_universe == '0 && rsp_ch.channel_red == '0 && rsp_ch.channel_green == '0 && rsp_ch.channel_blue == '0, "Failed item carries nonzero fields.")
   `DPCM_ASSERT(a_sacn_step, clock, reset, rsp_ch.valid && rsp_ch.ok |-> rsp_ch.sacn_universe == rsp_ch.artnet_universe + UNI_OUT_W'(1), "sACN universe is not Art-Net universe plus one.")
   `DPCM_ASSERT(a_blue_step, clock, reset, rsp_ch.valid && rsp_ch.ok |-> rsp_ch.channel_blue == rsp_ch.channel_red + CH_W'(2), "Blue slot is not red slot plus two.")
   `DPCM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_ch.valid, "Output valid after reset.")

endmodule

// File: hw/rtl/dmx_pixel_channel_mapper_top.sv
// Top level of the DMX pixel channel mapper.
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    pixel_index
//   rsp_ch    out        valid/ready    ok, offsets, universes, red/green/blue slots
//   csr_*     in         csr_we only    csr_index, csr_wdata
//
// A result passes through five register stages on its way from the accepting edge to the
// output: locate, quotient estimate, remainder, correction and output.
// A new item is accepted every cycle while the output side takes results.
// Reset is synchronous; it empties the pipeline and restores the register defaults.
// A stall holds each full stage; an empty stage still takes the item before it.
module dmx_pixel_channel_mapper_top #(
   parameter int UNIVERSE_SLOTS = dpcm_pkg::UNIVERSE_SLOTS_DEF,
   parameter int MAX_UNIVERSES  = dpcm_pkg::MAX_UNIVERSES_DEF,
   parameter int MAX_PIXELS     = dpcm_pkg::MAX_PIXELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   dpcm_req_if.sink                        req_ch,
   dpcm_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [dpcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dpcm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dpcm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    loc_valid, loc_ready, div_valid, div_ready;
   loc_type loc;
   div_type div;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_CHANNEL:  cfg_in.start_channel  = CH_W'(csr_wdata);
            CSR_PIXEL_COUNT:    cfg_in.pixel_count    = COUNT_W'(csr_wdata);
            CSR_WHITE_ENABLE:   cfg_in.white_enable   = csr_wdata[0];
            CSR_CCT_ENABLE:     cfg_in.cct_enable     = csr_wdata[0];
            CSR_START_UNIVERSE: cfg_in.start_universe = UNI_W'(csr_wdata);
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_channel  <= START_CHANNEL_RST;
         cfg_ff.pixel_count    <= PIXEL_COUNT_RST;
         cfg_ff.white_enable   <= 1'b0;
         cfg_ff.cct_enable     <= 1'b0;
         cfg_ff.start_universe <= START_UNIVERSE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dpcm_locate #(
      .UNIVERSE_SLOTS(UNIVERSE_SLOTS),
      .MAX_PIXELS(MAX_PIXELS)
   ) u_locate (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_ch(req_ch),
      .loc_valid(loc_valid),
      .loc_ready(loc_ready),
      .loc(loc)
   );

   dpcm_divide #(
      .UNIVERSE_SLOTS(UNIVERSE_SLOTS),
      .MAX_UNIVERSES(MAX_UNIVERSES)
   ) u_divide (
      .clock(clock),
      .reset(reset),
      .loc_valid(loc_valid),
      .loc_ready(loc_ready),
      .loc(loc),
      .div_valid(div_valid),
      .div_ready(div_ready),
      .div(div)
   );

   dpcm_format u_format (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .div_valid(div_valid),
      .div_ready(div_ready),
      .div(div),
      .rsp_ch(rsp_ch)
   );

endmodule
